// File: hdl/qslp_pkg.sv
package qslp_pkg;

  // Fixed-point formats.
  localparam int FRAC_BITS  = 14;
  localparam int ANG_BITS   = 30;
  localparam int SHIFT_UP   = ANG_BITS - FRAC_BITS;
  localparam int ONE        = 1 << FRAC_BITS;
  localparam int COMP_W     = 16;
  localparam int T_W        = 15;
  localparam int ACOMP_W    = COMP_W + 1;

  // Square root chain: one result bit per cell.
  localparam int ROOT_CELLS = FRAC_BITS + 1;
  localparam int RAD_W      = 2 * FRAC_BITS + 2;

  // CORDIC datapath width.
  localparam int CW         = 34;
  localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;

  // Divider chain: quotient is at most ONE, so FRAC_BITS + 1 bits.
  localparam int DIV_CELLS  = FRAC_BITS + 1;
  localparam int NUM_W      = 52;
  localparam int DEN_W      = 31;
  localparam int Q_W        = FRAC_BITS + 1;

  typedef struct packed {
    logic signed [CW-1:0] x;
    logic signed [CW-1:0] y;
    logic signed [CW-1:0] z;
  } cordic_t;

  typedef struct packed {
    logic [RAD_W-1:0] rem;
    logic [RAD_W-1:0] root;
  } root_t;

  typedef struct packed {
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [Q_W-1:0]   q;
    logic             neg;
    logic             sat;
  } quot_t;

  typedef struct packed {
    logic [3:0][ACOMP_W-1:0] an;
    logic [3:0][COMP_W-1:0]  b;
    logic [T_W-1:0]          t;
    logic                    lin;
    logic [3:0][COMP_W-1:0]  lres;
    logic [FRAC_BITS-1:0]    c;
  } side_t;

  // Arctangent of 2^-k in Q.30 radians.
  function automatic logic signed [CW-1:0] arc_angle(input int unsigned k);
    logic signed [CW-1:0] a;
    case (k)
      0:  a = 34'sd843314857;
      1:  a = 34'sd497837829;
      2:  a = 34'sd263043837;
      3:  a = 34'sd133525159;
      4:  a = 34'sd67021687;
      5:  a = 34'sd33543516;
      6:  a = 34'sd16775851;
      7:  a = 34'sd8388437;
      8:  a = 34'sd4194283;
      9:  a = 34'sd2097149;
      10: a = 34'sd1048576;
      11: a = 34'sd524288;
      12: a = 34'sd262144;
      13: a = 34'sd131072;
      14: a = 34'sd65536;
      15: a = 34'sd32768;
      16: a = 34'sd16384;
      17: a = 34'sd8192;
      18: a = 34'sd4096;
      19: a = 34'sd2048;
      20: a = 34'sd1024;
      21: a = 34'sd512;
      22: a = 34'sd256;
      23: a = 34'sd128;
      24: a = 34'sd64;
      25: a = 34'sd32;
      26: a = 34'sd16;
      27: a = 34'sd8;
      28: a = 34'sd4;
      29: a = 34'sd2;
      30: a = 34'sd1;
      default: a = '0;
    endcase
    return a;
  endfunction

  // Clamp to [-ONE, ONE] and keep the low 16 bits.
  function automatic logic [COMP_W-1:0] sat_comp(input logic signed [CW-1:0] v);
    logic [COMP_W-1:0] r;
    if (v > CW'(ONE)) begin
      r = COMP_W'(ONE);
    end else if (v < -CW'(ONE)) begin
      r = COMP_W'(-ONE);
    end else begin
      r = v[COMP_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: hdl/quaternion_slerp_core.sv
// Fixed-point quaternion slerp. Each transfer on the input side is taken when
// start is high; busy is always low, so a new pair of quaternions and a blend
// factor may enter in every clock cycle. Each item yields exactly one result,
// shown for one cycle with out_valid high. The receiver cannot stall the
// block, so it must take every result in the cycle it appears. The latency
// is set by the row of cells that each item walks through: a 15-cell square
// root, a vectoring CORDIC and a pair of rotation CORDICs of CORDIC_STAGES
// cells each, and a 15-cell divider per component, plus a handful of multiply
// and add stages.
module quaternion_slerp_core #(
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_first_x,
  input  logic [15:0] in_first_y,
  input  logic [15:0] in_first_z,
  input  logic [15:0] in_first_w,
  input  logic [15:0] in_second_x,
  input  logic [15:0] in_second_y,
  input  logic [15:0] in_second_z,
  input  logic [15:0] in_second_w,
  input  logic [14:0] in_blend,
  output logic        out_valid,
  output logic [15:0] out_x,
  output logic [15:0] out_y,
  output logic [15:0] out_z,
  output logic [15:0] out_w,
  output logic        out_used_linear
);
  import qslp_pkg::*;

  localparam int CS     = CORDIC_STAGES;
  localparam int LAT    = 39 + 2 * CS;
  localparam int SIDE_N = 34 + 2 * CS;
  localparam int S_N    = 2 * CS + 1;
  // Taps into the side line; side_r[0] holds stage 5.
  localparam int TAP_VEC = 15;
  localparam int TAP_MUL = 15 + CS;
  localparam int TAP_PRD = 16 + 2 * CS;
  localparam int TAP_OUT = 33 + 2 * CS;

  // The pipeline never stalls.
  assign busy = 1'b0;

  // Valid marks travel alongside the data.
  logic v_r [LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        v_r[i] <= 1'b0;
      end
    end else begin
      v_r[0] <= start && !busy;
      for (int i = 1; i < LAT; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  // Stage 1: capture the operands and clamp the blend factor to one.
  logic signed [COMP_W-1:0] a1_r [4];
  logic signed [COMP_W-1:0] b1_r [4];
  logic [T_W-1:0]           t1_r;

  always_ff @(posedge clk) begin
    a1_r[0] <= in_first_x;
    a1_r[1] <= in_first_y;
    a1_r[2] <= in_first_z;
    a1_r[3] <= in_first_w;
    b1_r[0] <= in_second_x;
    b1_r[1] <= in_second_y;
    b1_r[2] <= in_second_z;
    b1_r[3] <= in_second_w;
    t1_r    <= (in_blend > T_W'(ONE)) ? T_W'(ONE) : in_blend;
  end

  // Stage 2: the four products of the dot product.
  logic signed [31:0]       p2_r [4];
  logic signed [COMP_W-1:0] a2_r [4];
  logic signed [COMP_W-1:0] b2_r [4];
  logic [T_W-1:0]           t2_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      p2_r[k] <= a1_r[k] * b1_r[k];
      a2_r[k] <= a1_r[k];
      b2_r[k] <= b1_r[k];
    end
    t2_r <= t1_r;
  end

  // Stage 3: sum of the products.
  logic signed [33:0]       in3_r;
  logic signed [COMP_W-1:0] a3_r [4];
  logic signed [COMP_W-1:0] b3_r [4];
  logic [T_W-1:0]           t3_r;

  always_ff @(posedge clk) begin
    in3_r <= 34'(p2_r[0]) + 34'(p2_r[1]) + 34'(p2_r[2]) + 34'(p2_r[3]);
    for (int k = 0; k < 4; k++) begin
      a3_r[k] <= a2_r[k];
      b3_r[k] <= b2_r[k];
    end
    t3_r <= t2_r;
  end

  // Stage 4: take the short way round by flipping the first quaternion when
  // the dot product is negative, then pick the linear or the arc path.
  logic signed [33:0]        mag3;
  logic [18:0]               c3;
  logic signed [ACOMP_W-1:0] an4_r [4];
  logic signed [COMP_W-1:0]  b4_r [4];
  logic [T_W-1:0]            t4_r;
  logic [18:0]               c4_r;
  logic                      lin4_r;

  always_comb begin
    mag3 = in3_r[33] ? -in3_r : in3_r;
    c3   = mag3[FRAC_BITS +: 19];
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      an4_r[k] <= in3_r[33] ? -ACOMP_W'(a3_r[k]) : ACOMP_W'(a3_r[k]);
      b4_r[k]  <= b3_r[k];
    end
    t4_r   <= t3_r;
    c4_r   <= c3;
    lin4_r <= c3 >= 19'(ONE - 1);
  end

  // Stage 5: linear blend of every component, and the radicand 1 - c^2 for
  // the sine of the angle.
  logic signed [17:0]            ldiff [4];
  logic signed [CW-1:0]          lprod [4];
  logic signed [CW-1:0]          lsum  [4];
  logic [2*FRAC_BITS-1:0]        csq;
  side_t                         side5;
  side_t                         side_r [SIDE_N];
  root_t                         root_in_r;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      ldiff[k] = 18'(b4_r[k]) - 18'(an4_r[k]);
      lprod[k] = CW'(ldiff[k]) * CW'(signed'({1'b0, t4_r}));
      lsum[k]  = CW'(an4_r[k]) + (lprod[k] >>> FRAC_BITS);
      side5.an[k]   = an4_r[k];
      side5.b[k]    = b4_r[k];
      side5.lres[k] = sat_comp(lsum[k]);
    end
    side5.t   = t4_r;
    side5.lin = lin4_r;
    side5.c   = c4_r[FRAC_BITS-1:0];
    csq       = c4_r[FRAC_BITS-1:0] * c4_r[FRAC_BITS-1:0];
  end

  always_ff @(posedge clk) begin
    side_r[0]      <= side5;
    for (int i = 1; i < SIDE_N; i++) begin
      side_r[i] <= side_r[i-1];
    end
    root_in_r.rem  <= ({{(RAD_W-1){1'b0}}, 1'b1} << (2 * FRAC_BITS)) - RAD_W'(csq);
    root_in_r.root <= '0;
  end

  // Square root chain: s = floor(sqrt(1 - c^2)) in Q.14.
  root_t sq [ROOT_CELLS+1];
  assign sq[0] = root_in_r;

  for (genvar i = 0; i < ROOT_CELLS; i++) begin : g_sqrt
    qslp_sqrt_cell #(.POS(FRAC_BITS - i)) u_cell (
      .clk  (clk),
      .din  (sq[i]),
      .dout (sq[i+1])
    );
  end

  // The root waits in its own line until the divider needs it.
  logic [FRAC_BITS:0] s_r [S_N];

  always_ff @(posedge clk) begin
    s_r[0] <= sq[ROOT_CELLS].root[FRAC_BITS:0];
    for (int i = 1; i < S_N; i++) begin
      s_r[i] <= s_r[i-1];
    end
  end

  // Vectoring CORDIC: angle = atan2(s, c) in Q.30.
  cordic_t cv [CS+1];
  assign cv[0].x = CW'(side_r[TAP_VEC].c) << SHIFT_UP;
  assign cv[0].y = CW'(sq[ROOT_CELLS].root[FRAC_BITS:0]) << SHIFT_UP;
  assign cv[0].z = '0;

  for (genvar i = 0; i < CS; i++) begin : g_vec
    qslp_cordic_cell #(.IDX(i), .ROTATE(1'b0)) u_cell (
      .clk  (clk),
      .din  (cv[i]),
      .dout (cv[i+1])
    );
  end

  // Split the angle by the blend factor.
  logic [30:0]     ang;
  logic [T_W-1:0]  tm;
  logic [46:0]     wa_full;
  logic [46:0]     wb_full;
  logic [30:0]     wa_r;
  logic [30:0]     wb_r;

  always_comb begin
    ang     = cv[CS].z[CW-1] ? '0 : cv[CS].z[30:0];
    tm      = side_r[TAP_MUL].t;
    wa_full = 47'(T_W'(ONE) - tm) * 47'(ang);
    wb_full = 47'(tm) * 47'(ang);
  end

  always_ff @(posedge clk) begin
    wa_r <= wa_full[FRAC_BITS +: 31];
    wb_r <= wb_full[FRAC_BITS +: 31];
  end

  // Rotation CORDICs: sin of each share of the angle.
  cordic_t cra [CS+1];
  cordic_t crb [CS+1];
  assign cra[0].x = CORDIC_K;
  assign cra[0].y = '0;
  assign cra[0].z = CW'(wa_r);
  assign crb[0].x = CORDIC_K;
  assign crb[0].y = '0;
  assign crb[0].z = CW'(wb_r);

  for (genvar i = 0; i < CS; i++) begin : g_rot
    qslp_cordic_cell #(.IDX(i), .ROTATE(1'b1)) u_cell_a (
      .clk  (clk),
      .din  (cra[i]),
      .dout (cra[i+1])
    );
    qslp_cordic_cell #(.IDX(i), .ROTATE(1'b1)) u_cell_b (
      .clk  (clk),
      .din  (crb[i]),
      .dout (crb[i+1])
    );
  end

  // Weight both quaternions by their sines.
  logic signed [NUM_W-1:0] pa_r [4];
  logic signed [NUM_W-1:0] pb_r [4];
  logic [DEN_W-1:0]        den_r;

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      pa_r[k] <= NUM_W'($signed(side_r[TAP_PRD].an[k])) * NUM_W'(cra[CS].y);
      pb_r[k] <= NUM_W'($signed(side_r[TAP_PRD].b[k])) * NUM_W'(crb[CS].y);
    end
    den_r <= DEN_W'(s_r[S_N-1]) << SHIFT_UP;
  end

  // Sum, split into sign and magnitude, and flag quotients past one.
  logic signed [NUM_W-1:0] num   [4];
  logic [NUM_W-1:0]        nmag  [4];
  logic [NUM_W-1:0]        limit;
  quot_t                   dq    [4][DIV_CELLS+1];

  always_comb begin
    limit = (NUM_W'(den_r) << FRAC_BITS) + NUM_W'(den_r);
    for (int k = 0; k < 4; k++) begin
      num[k]  = pa_r[k] + pb_r[k];
      nmag[k] = num[k][NUM_W-1] ? -num[k] : num[k];
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_comp
    quot_t div_in_r;

    always_ff @(posedge clk) begin
      div_in_r.rem <= nmag[k];
      div_in_r.den <= den_r;
      div_in_r.q   <= '0;
      div_in_r.neg <= num[k][NUM_W-1];
      div_in_r.sat <= nmag[k] >= limit;
    end

    assign dq[k][0] = div_in_r;

    for (genvar i = 0; i < DIV_CELLS; i++) begin : g_div
      qslp_div_cell #(.POS(FRAC_BITS - i)) u_cell (
        .clk  (clk),
        .din  (dq[k][i]),
        .dout (dq[k][i+1])
      );
    end
  end

  // Output stage: pick the path, apply the sign, saturate.
  logic [COMP_W-1:0] qmag   [4];
  logic [COMP_W-1:0] arcres [4];
  logic [COMP_W-1:0] res_r  [4];
  logic              lin_r;
  side_t             side_o;

  always_comb begin
    side_o = side_r[TAP_OUT];
    for (int k = 0; k < 4; k++) begin
      qmag[k]   = dq[k][DIV_CELLS].sat ? COMP_W'(ONE) : COMP_W'(dq[k][DIV_CELLS].q);
      arcres[k] = dq[k][DIV_CELLS].neg ? -qmag[k] : qmag[k];
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < 4; k++) begin
      res_r[k] <= side_o.lin ? side_o.lres[k] : arcres[k];
    end
    lin_r <= side_o.lin;
  end

  assign out_valid       = v_r[LAT-1];
  assign out_x           = res_r[0];
  assign out_y           = res_r[1];
  assign out_z           = res_r[2];
  assign out_w           = res_r[3];
  assign out_used_linear = lin_r;

endmodule

// File: hdl/qslp_sqrt_cell.sv
module qslp_sqrt_cell #(
  parameter int POS = 0
) (
  input  logic            clk,
  input  qslp_pkg::root_t din,
  output qslp_pkg::root_t dout
);
  import qslp_pkg::*;

  localparam logic [RAD_W-1:0] BIT_VAL = {{(RAD_W-1){1'b0}}, 1'b1} << (2 * POS);

  root_t            dout_r;
  root_t            dout_nxt;
  logic [RAD_W-1:0] trial;

  // One restoring step: settles one bit of the root.
  always_comb begin
    trial = din.root + BIT_VAL;
    if (din.rem >= trial) begin
      dout_nxt.rem  = din.rem - trial;
      dout_nxt.root = (din.root >> 1) + BIT_VAL;
    end else begin
      dout_nxt.rem  = din.rem;
      dout_nxt.root = din.root >> 1;
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
  end

  assign dout = dout_r;

endmodule

// File: hdl/qslp_cordic_cell.sv
module qslp_cordic_cell #(
  parameter int IDX    = 0,
  parameter bit ROTATE = 1'b0
) (
  input  logic              clk,
  input  qslp_pkg::cordic_t din,
  output qslp_pkg::cordic_t dout
);
  import qslp_pkg::*;

  localparam int K = IDX % 32;

  cordic_t              dout_r;
  cordic_t              dout_nxt;
  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [CW-1:0] atn;
  logic                 pos;

  // Vectoring drives y toward zero; rotation drives z toward zero.
  always_comb begin
    dx  = din.y >>> K;
    dy  = din.x >>> K;
    atn = arc_angle(K);
    pos = ROTATE ? !din.z[CW-1] : !din.y[CW-1];
    if (ROTATE) begin
      dout_nxt.x = pos ? din.x - dx : din.x + dx;
      dout_nxt.y = pos ? din.y + dy : din.y - dy;
      dout_nxt.z = pos ? din.z - atn : din.z + atn;
    end else begin
      dout_nxt.x = pos ? din.x + dx : din.x - dx;
      dout_nxt.y = pos ? din.y - dy : din.y + dy;
      dout_nxt.z = pos ? din.z + atn : din.z - atn;
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
  end

  assign dout = dout_r;

endmodule

// File: hdl/qslp_div_cell.sv
module qslp_div_cell #(
  parameter int POS = 0
) (
  input  logic            clk,
  input  qslp_pkg::quot_t din,
  output qslp_pkg::quot_t dout
);
  import qslp_pkg::*;

  quot_t            dout_r;
  quot_t            dout_nxt;
  logic [NUM_W-1:0] trial;

  // One restoring division step: settles quotient bit POS.
  always_comb begin
    trial    = {{(NUM_W-DEN_W){1'b0}}, din.den} << POS;
    dout_nxt = din;
    if (din.rem >= trial) begin
      dout_nxt.rem    = din.rem - trial;
      dout_nxt.q[POS] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    dout_r <= dout_nxt;
  end

  assign dout = dout_r;

endmodule

// File: hdl/qslp_checker.sv
module qslp_checker #(
  parameter int CORDIC_STAGES = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [15:0] out_x,
  input logic [15:0] out_y,
  input logic [15:0] out_z,
  input logic [15:0] out_w,
  input logic        out_used_linear
);

  localparam int LAT = 39 + 2 * CORDIC_STAGES;

  // The pipeline always takes a new item.
  a_never_busy : assert property (@(posedge clk) disable iff (!rst_n)
    !busy)
    else $error("busy raised");

  // Every result comes from a transfer exactly one latency earlier.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LAT))
    else $error("result without matching input transfer");

  // Results stay within [-1, 1] in Q1.14.
  a_range_xy : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_x) <= 16384 && $signed(out_x) >= -16384 &&
                   $signed(out_y) <= 16384 && $signed(out_y) >= -16384))
    else $error("x or y out of range");

  a_range_zw : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($signed(out_z) <= 16384 && $signed(out_z) >= -16384 &&
                   $signed(out_w) <= 16384 && $signed(out_w) >= -16384))
    else $error("z or w out of range");

endmodule

bind quaternion_slerp_core qslp_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_qslp_checker (.*);
